### rtl/core/bba_pkg.sv
package bba_pkg;

  // Fixed field widths of the request, response and configuration words.
  localparam int IDX_W     = 14;
  localparam int CNT_W     = 15;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 1;

  // Defaults for the top-level parameters.
  localparam int MAX_BLOCKS_DEF    = 16384;
  localparam int MAP_WORD_BITS_DEF = 64;

  // Register reset values.
  localparam logic [CFG_W-1:0] TOTAL_RESET    = 15'd16384;
  localparam logic [CFG_W-1:0] RESERVED_RESET = 15'd0;

  typedef enum logic [2:0] {
    ACT_READ   = 3'd0,
    ACT_WRITE  = 3'd1,
    ACT_ALLOC  = 3'd2,
    ACT_FREE   = 3'd3,
    ACT_FORMAT = 3'd4
  } action_t;

  typedef enum logic [1:0] {
    STS_OK           = 2'd0,
    STS_NO_FREE      = 2'd1,
    STS_OUT_OF_RANGE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL    = 1'b0,
    REG_RESERVED = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    action_t            action;
    logic [IDX_W-1:0]   block_index;
    logic               bit_value;
  } req_word_t;

  typedef struct packed {
    logic [IDX_W-1:0]   result_block;
    logic               read_value;
    logic [CNT_W-1:0]   free_left;
    status_t            status;
  } rsp_word_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_RDREQ,
    S_RMW,
    S_SCAN,
    S_GROUP,
    S_BIT,
    S_AWRITE,
    S_FORMAT,
    S_DONE
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic set_oor;
    logic set_nofree;
    logic div;
    logic rd_req;
    logic rmw;
    logic scan_start;
    logic scan_step;
    logic hit_load;
    logic group;
    logic bit_find;
    logic awrite;
    logic sweep_start;
    logic sweep;
    logic fmt_count;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    action_t action;
    logic    idx_oor;
    logic    count_zero;
    logic    scan_hit;
    logic    scan_end;
    logic    sweep_last;
    logic    out_free;
  } sts_t;

endpackage

### rtl/core/bba_ram.sv
module bba_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr,
  input  logic [Width-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr,
  output logic [Width-1:0]                             rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/bba_ctrl.sv
module bba_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bba_pkg::sts_t  sts,
  output bba_pkg::cmd_t  cmd
);

  bba_pkg::ctl_state_t state;
  bba_pkg::ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bba_pkg::S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      bba_pkg::S_INIT: begin
        if (sts.sweep_last) state_next = bba_pkg::S_IDLE;
      end
      bba_pkg::S_IDLE: begin
        if (req_valid) state_next = bba_pkg::S_DECODE;
      end
      bba_pkg::S_DECODE: begin
        unique case (sts.action) inside
          bba_pkg::ACT_READ, bba_pkg::ACT_WRITE, bba_pkg::ACT_FREE: begin
            state_next = sts.idx_oor ? bba_pkg::S_DONE : bba_pkg::S_DIV;
          end
          bba_pkg::ACT_ALLOC: begin
            state_next = sts.count_zero ? bba_pkg::S_DONE : bba_pkg::S_SCAN;
          end
          bba_pkg::ACT_FORMAT: begin
            state_next = bba_pkg::S_FORMAT;
          end
          default: begin
            state_next = bba_pkg::S_DONE;
          end
        endcase
      end
      bba_pkg::S_DIV:    state_next = bba_pkg::S_RDREQ;
      bba_pkg::S_RDREQ:  state_next = bba_pkg::S_RMW;
      bba_pkg::S_RMW:    state_next = bba_pkg::S_DONE;
      bba_pkg::S_SCAN: begin
        if (sts.scan_hit) begin
          state_next = bba_pkg::S_GROUP;
        end else if (sts.scan_end) begin
          state_next = bba_pkg::S_DONE;
        end
      end
      bba_pkg::S_GROUP:  state_next = bba_pkg::S_BIT;
      bba_pkg::S_BIT:    state_next = bba_pkg::S_AWRITE;
      bba_pkg::S_AWRITE: state_next = bba_pkg::S_DONE;
      bba_pkg::S_FORMAT: begin
        if (sts.sweep_last) state_next = bba_pkg::S_DONE;
      end
      bba_pkg::S_DONE: begin
        if (sts.out_free) state_next = bba_pkg::S_IDLE;
      end
      default: state_next = bba_pkg::S_INIT;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = (state != bba_pkg::S_IDLE);
    unique case (state)
      bba_pkg::S_INIT: begin
        cmd.sweep = 1'b1;
      end
      bba_pkg::S_IDLE: begin
        cmd.take = req_valid;
      end
      bba_pkg::S_DECODE: begin
        unique case (sts.action) inside
          bba_pkg::ACT_READ, bba_pkg::ACT_WRITE, bba_pkg::ACT_FREE: begin
            cmd.set_oor = sts.idx_oor;
          end
          bba_pkg::ACT_ALLOC: begin
            cmd.set_nofree = sts.count_zero;
            cmd.scan_start = !sts.count_zero;
          end
          bba_pkg::ACT_FORMAT: begin
            cmd.sweep_start = 1'b1;
          end
          default: begin
          end
        endcase
      end
      bba_pkg::S_DIV:    cmd.div = 1'b1;
      bba_pkg::S_RDREQ:  cmd.rd_req = 1'b1;
      bba_pkg::S_RMW:    cmd.rmw = 1'b1;
      bba_pkg::S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.hit_load = 1'b1;
        end else if (sts.scan_end) begin
          cmd.set_nofree = 1'b1;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      bba_pkg::S_GROUP:  cmd.group = 1'b1;
      bba_pkg::S_BIT:    cmd.bit_find = 1'b1;
      bba_pkg::S_AWRITE: cmd.awrite = 1'b1;
      bba_pkg::S_FORMAT: begin
        cmd.sweep     = 1'b1;
        cmd.fmt_count = sts.sweep_last;
      end
      bba_pkg::S_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/bba_dp.sv
module bba_dp #(
  parameter int MaxBlocks = bba_pkg::MAX_BLOCKS_DEF,
  parameter int WordBits  = bba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  bba_pkg::cmd_t                   cmd,
  output bba_pkg::sts_t                   sts,
  input  bba_pkg::req_word_t              req_word,
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]       cfg_data,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output bba_pkg::rsp_word_t              rsp_word
);

  localparam int IdxW     = bba_pkg::IDX_W;
  localparam int CntW     = bba_pkg::CNT_W;
  localparam int Words    = (MaxBlocks + WordBits - 1) / WordBits;
  localparam int AW       = (Words > 1) ? $clog2(Words) : 1;
  localparam int KW       = $clog2(WordBits);
  localparam int BW       = $clog2((Words + 2) * WordBits);
  localparam int CW       = ((BW > CntW) ? BW : CntW) + 1;
  localparam int Groups   = (WordBits + 7) / 8;
  localparam int GW       = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int PW       = GW + 3;
  localparam int PadW     = 1 << PW;
  // Reciprocal of the word size, exact for every index below 2**IdxW.
  localparam int DivShift = IdxW + KW + 1;
  localparam int Recip    = ((1 << DivShift) + WordBits - 1) / WordBits;
  localparam int RecW     = DivShift - 2;
  localparam int ProdW    = IdxW + RecW;
  localparam logic [WordBits-1:0] WordOne  = {{(WordBits - 1){1'b0}}, 1'b1};
  localparam logic [KW-1:0]       TopBit   = KW'(WordBits - 1);
  localparam logic [BW-1:0]       BaseStep = BW'(WordBits);

  // Configuration and counters.
  logic [CntW-1:0] total;
  logic [CntW-1:0] reserved;
  logic [CntW-1:0] free_count;
  logic [CntW-1:0] tot;
  logic [CntW-1:0] res_clamp;

  // Current item.
  bba_pkg::action_t act;
  logic [IdxW-1:0]  idx;
  logic             val;

  // Single-bit access.
  logic [AW-1:0]    q_reg;
  logic [KW-1:0]    rem_reg;
  logic [ProdW-1:0] div_prod;
  logic [IdxW-1:0]  qw;
  logic [IdxW-1:0]  rem_d;
  logic [KW-1:0]    pos_rmw;
  logic [WordBits-1:0] mask_rmw;

  // Allocation scan.
  logic [AW-1:0]       scan_addr;
  logic [BW-1:0]       scan_base;
  logic                p1_valid;
  logic [AW-1:0]       p1_addr;
  logic [BW-1:0]       p1_base;
  logic [WordBits-1:0] effr;
  logic                scan_past;
  logic [AW-1:0]       hit_addr;
  logic [BW-1:0]       hit_base;
  logic [WordBits-1:0] hit_word;
  logic [WordBits-1:0] hit_effr;
  logic [PadW-1:0]     pad;
  logic [(1 << GW)-1:0] gz;
  logic [GW-1:0]       g_first;
  logic [GW-1:0]       grp;
  logic [7:0]          grp_bits;
  logic [2:0]          j_first;
  logic [PW-1:0]       kfull;
  logic [CW-1:0]       blk_sum;
  logic [KW-1:0]       kpos;
  logic [KW-1:0]       pos_al;

  // Format sweep.
  logic [AW-1:0]       sweep_addr;
  logic [BW-1:0]       sweep_base;
  logic [CntW-1:0]     fmt_res;
  logic [WordBits-1:0] fmt_word;

  // Result under construction.
  logic [IdxW-1:0]     res_block;
  logic                res_rd;
  bba_pkg::status_t    res_status;

  // Map RAM ports.
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [WordBits-1:0] ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [WordBits-1:0] ram_rdata;

  bba_ram #(
    .Width (WordBits),
    .Depth (Words)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign tot       = (32'(total) > 32'(MaxBlocks)) ? CntW'(MaxBlocks) : total;
  assign res_clamp = (reserved > tot) ? tot : reserved;

  assign div_prod = ProdW'(idx) * ProdW'(Recip);
  assign qw       = IdxW'(q_reg) * IdxW'(WordBits);
  assign rem_d    = idx - qw;
  assign pos_rmw  = TopBit - rem_reg;
  assign mask_rmw = WordOne << pos_rmw;

  // Words are held most significant bit first; effr is the scanned word in
  // block order, with blocks at or past the limit forced to look used.
  always_comb begin
    for (int k = 0; k < WordBits; k++) begin
      effr[k] = ram_rdata[WordBits - 1 - k] |
                ((CW'(p1_base) + CW'(k)) >= CW'(tot));
      fmt_word[WordBits - 1 - k] = (CW'(sweep_base) + CW'(k)) < CW'(fmt_res);
    end
  end

  assign scan_past = CW'(p1_base) >= CW'(tot);

  always_comb begin
    for (int k = 0; k < PadW; k++) begin
      pad[k] = (k < WordBits) ? hit_effr[k] : 1'b1;
    end
    for (int g = 0; g < (1 << GW); g++) begin
      gz[g] = ~&pad[g * 8 +: 8];
    end
    g_first = '0;
    for (int g = (1 << GW) - 1; g >= 0; g--) begin
      if (gz[g]) g_first = GW'(g);
    end
  end

  assign grp_bits = pad[{grp, 3'b000} +: 8];

  always_comb begin
    j_first = '0;
    for (int j = 7; j >= 0; j--) begin
      if (!grp_bits[j]) j_first = 3'(j);
    end
  end

  assign kfull   = {grp, j_first};
  assign blk_sum = CW'(hit_base) + CW'(kfull);
  assign pos_al  = TopBit - kpos;

  // RAM port selection.
  always_comb begin
    ram_re    = cmd.rd_req | cmd.scan_step;
    ram_raddr = cmd.rd_req ? q_reg : scan_addr;
    ram_we    = cmd.sweep | cmd.awrite |
                (cmd.rmw && (act == bba_pkg::ACT_WRITE || act == bba_pkg::ACT_FREE));
    if (cmd.sweep) begin
      ram_waddr = sweep_addr;
      ram_wdata = fmt_word;
    end else if (cmd.awrite) begin
      ram_waddr = hit_addr;
      ram_wdata = hit_word | (WordOne << pos_al);
    end else begin
      ram_waddr = q_reg;
      ram_wdata = (act == bba_pkg::ACT_WRITE && val) ? (ram_rdata | mask_rmw)
                                                    : (ram_rdata & ~mask_rmw);
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      total      <= bba_pkg::TOTAL_RESET;
      reserved   <= bba_pkg::RESERVED_RESET;
      free_count <= '0;
      sweep_addr <= '0;
      sweep_base <= '0;
      fmt_res    <= '0;
      p1_valid   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          bba_pkg::REG_TOTAL:    total    <= cfg_data;
          bba_pkg::REG_RESERVED: reserved <= cfg_data;
          default: begin
          end
        endcase
      end

      if (cmd.fmt_count) begin
        free_count <= tot - fmt_res;
      end else if (cmd.rmw && act == bba_pkg::ACT_FREE && free_count < tot) begin
        free_count <= free_count + 1'b1;
      end else if (cmd.awrite) begin
        free_count <= free_count - 1'b1;
      end

      if (cmd.sweep_start) begin
        sweep_addr <= '0;
        sweep_base <= '0;
        fmt_res    <= res_clamp;
      end else if (cmd.sweep) begin
        sweep_addr <= sweep_addr + 1'b1;
        sweep_base <= sweep_base + BaseStep;
      end

      if (cmd.scan_start) begin
        p1_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        p1_valid <= 1'b1;
      end

      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act        <= req_word.action;
      idx        <= req_word.block_index;
      val        <= req_word.bit_value;
      res_block  <= (req_word.action == bba_pkg::ACT_ALLOC ||
                     req_word.action == bba_pkg::ACT_FORMAT) ? '0 : req_word.block_index;
      res_rd     <= 1'b0;
      res_status <= bba_pkg::STS_OK;
    end
    if (cmd.set_oor) res_status <= bba_pkg::STS_OUT_OF_RANGE;
    if (cmd.set_nofree) res_status <= bba_pkg::STS_NO_FREE;
    if (cmd.div) q_reg <= AW'(div_prod >> DivShift);
    if (cmd.rd_req) rem_reg <= rem_d[KW-1:0];
    if (cmd.rmw && act == bba_pkg::ACT_READ) res_rd <= ram_rdata[pos_rmw];

    if (cmd.scan_start) begin
      scan_addr <= '0;
      scan_base <= '0;
    end else if (cmd.scan_step) begin
      p1_addr   <= scan_addr;
      p1_base   <= scan_base;
      scan_addr <= scan_addr + 1'b1;
      scan_base <= scan_base + BaseStep;
    end

    if (cmd.hit_load) begin
      hit_addr <= p1_addr;
      hit_base <= p1_base;
      hit_word <= ram_rdata;
      hit_effr <= effr;
    end
    if (cmd.group) grp <= g_first;
    if (cmd.bit_find) begin
      kpos      <= kfull[KW-1:0];
      res_block <= blk_sum[IdxW-1:0];
    end

    if (cmd.load_out) begin
      rsp_word.result_block <= res_block;
      rsp_word.read_value   <= res_rd;
      rsp_word.free_left    <= free_count;
      rsp_word.status       <= res_status;
    end
  end

  always_comb begin
    sts.action     = act;
    sts.idx_oor    = {1'b0, idx} >= tot;
    sts.count_zero = (free_count == '0);
    sts.scan_hit   = p1_valid && !scan_past && !(&effr);
    sts.scan_end   = p1_valid && scan_past;
    sts.sweep_last = (sweep_addr == AW'(Words - 1));
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

endmodule

### rtl/core/bitmap_block_allocator_top.sv
// One request at a time; the next can be taken in the cycle after the response word loads.
// Reset: synchronous, active high; afterwards a clearing pass writes all MAP_WORDS map words
// with req_stall high, while configuration writes are still taken.
module bitmap_block_allocator_top #(
  parameter int MAX_BLOCKS    = bba_pkg::MAX_BLOCKS_DEF,
  parameter int MAP_WORD_BITS = bba_pkg::MAP_WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Request channel.
  input  logic                            req_valid,
  output logic                            req_stall,
  input  bba_pkg::req_word_t              req_word,
  // Response channel.
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output bba_pkg::rsp_word_t              rsp_word,
  // Configuration write port.
  input  logic                            cfg_we,
  input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bba_pkg::CFG_W-1:0]       cfg_data
);

  // The controller sequences each request through the datapath: a decode
  // step, then either a locate/read-modify-write on one map word, a scan
  // over the map for allocate, a full sweep for format, or none of these
  // for a rejected request. The datapath holds the map RAM, the free block
  // counter, the configuration registers and the response register.
  //
  // The response register parts the two channels, so a new request word can
  // be taken while the previous response word still waits downstream. The
  // controller only holds at the end of a request until that register frees.

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Block numbers inside a map word run from the most significant bit down.
  // Allocate scans one word per cycle with the RAM read pipelined against the
  // zero test, then narrows the first word with a free block to a group of
  // eight bits and then to the bit itself before writing it back.
  bba_dp #(
    .MaxBlocks (MAX_BLOCKS),
    .WordBits  (MAP_WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_word  (req_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
  );

endmodule

### rtl/core/bba_checker.sv
module bba_checker #(
  parameter int MaxBlocks = bba_pkg::MAX_BLOCKS_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_stall,
  input logic                            rsp_valid,
  input logic                            rsp_stall,
  input bba_pkg::rsp_word_t              rsp_word
);

  // A stalled response word stays put.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
    else $error("response word changed while stalled");

  // The request channel is closed as the clearing pass after reset begins.
  a_reset_stall: assert property (@(posedge clk)
    $past(rst) |-> req_stall)
    else $error("request taken during the clearing pass");

  // One request at a time: after a word is taken, the next one waits.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("back-to-back request accepted");

  // The free count never goes beyond what the map can hold.
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp_word.free_left) <= 32'(MaxBlocks)))
    else $error("free count above map size");

  // A failed allocate reports no block.
  a_nofree_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_word.status == bba_pkg::STS_NO_FREE |->
      rsp_word.result_block == '0 && !rsp_word.read_value)
    else $error("failed allocate returned a block");

endmodule

bind bitmap_block_allocator_top bba_checker #(.MaxBlocks(MAX_BLOCKS)) u_bba_checker (.*);
